### hw/rtl/srld_pkg.sv
// Shared constants, types and helpers of the scanline run-length pixel decoder.
package srld_pkg;

  // Widths of the fields
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COL_W   = 12;
  localparam int unsigned COUNT_W = 5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_INDEX = 1'd1;

  // Register reset values
  localparam logic [COL_W-1:0] ROW_WIDTH_RST   = 12'd64;
  localparam logic [IDX_W-1:0] CLEAR_INDEX_RST = 8'd254;

  // Run code marker and count field
  localparam logic [IDX_W-1:0] RUN_MARK       = 8'he0;
  localparam logic [IDX_W-1:0] RUN_COUNT_MASK = 8'h1f;

  // Command queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One span of identical pixels: index, first column, pixel count (never zero)
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COL_W-1:0]   col;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  // Check whether a byte is a run code
  function automatic logic is_run_code(input logic [IDX_W-1:0] b);
    is_run_code = ((b & RUN_MARK) == RUN_MARK);
  endfunction

endpackage

### hw/rtl/srld_code_if.sv
// Stream interface carrying compressed code words into the decoder.
interface srld_code_if;
  import srld_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] data_byte;
  logic             row_end;

  modport source (output valid, output data_byte, output row_end, input ready);
  modport sink   (input valid, input data_byte, input row_end, output ready);
endinterface

### hw/rtl/srld_pixel_if.sv
// Stream interface carrying decoded pixel words out of the decoder.
interface srld_pixel_if;
  import srld_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;
  logic [COL_W-1:0] column;
  logic             transparent;
  logic             super_transparent;
  logic             last;

  modport source (output valid, output pixel_index, output column, output transparent,
                  output super_transparent, output last, input ready);
  modport sink   (input valid, input pixel_index, input column, input transparent,
                  input super_transparent, input last, output ready);
endinterface

### hw/rtl/srld_front.sv
// Front end: accept code words, track row position and run state, issue pixel spans.
module srld_front
  import srld_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [COL_W-1:0] row_width,
  srld_code_if.sink        codes,
  output logic             push_valid,
  input  logic             push_ready,
  output cmd_t             push_cmd
);

  logic [COL_W-1:0]   column_count;
  logic [COL_W-1:0]   column_count_next;
  logic               awaiting;
  logic               awaiting_next;
  logic [COUNT_W-1:0] pending_run;
  logic [COUNT_W-1:0] pending_run_next;

  logic               accept;
  logic               has_room;
  logic [COL_W-1:0]   left;
  logic [COUNT_W-1:0] raw_count;
  logic [COUNT_W-1:0] clip_count;

  // Take a word only when the queue can hold whatever it produces
  assign codes.ready = push_ready;
  assign accept      = codes.valid & codes.ready;

  // Pixels still free in the row
  assign has_room = (column_count < row_width);
  assign left     = has_room ? (row_width - column_count) : '0;

  // Count to clip: the awaited run, or the count field of a new run code
  assign raw_count  = awaiting ? pending_run : codes.data_byte[COUNT_W-1:0];
  assign clip_count = (left < {{(COL_W-COUNT_W){1'b0}}, raw_count}) ? left[COUNT_W-1:0]
                                                                     : raw_count;

  // Classify the word and work out the next row state
  always_comb begin
    column_count_next = column_count;
    awaiting_next     = awaiting;
    pending_run_next  = pending_run;
    push_valid        = 1'b0;
    push_cmd.idx      = codes.data_byte;
    push_cmd.col      = column_count;
    push_cmd.count    = clip_count;
    if (accept) begin
      if (awaiting) begin
        push_valid        = (clip_count != '0);
        column_count_next = column_count + {{(COL_W-COUNT_W){1'b0}}, clip_count};
        awaiting_next     = 1'b0;
        pending_run_next  = '0;
      end else if (has_room) begin
        if (is_run_code(codes.data_byte)) begin
          pending_run_next = clip_count;
          awaiting_next    = 1'b1;
        end else begin
          push_valid        = 1'b1;
          push_cmd.count    = COUNT_W'(1);
          column_count_next = column_count + COL_W'(1);
        end
      end
      if (codes.row_end) begin
        column_count_next = '0;
        awaiting_next     = 1'b0;
        pending_run_next  = '0;
      end
    end
  end

  // Hold row state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      awaiting     <= 1'b0;
      pending_run  <= '0;
    end else begin
      column_count <= column_count_next;
      awaiting     <= awaiting_next;
      pending_run  <= pending_run_next;
    end
  end

endmodule

### hw/rtl/srld_queue.sv
// Short span queue decoupling the front end from the pixel back end.
module srld_queue
  import srld_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Store spans
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/srld_back.sv
// Back end: expand spans into pixel words and flag transparency.
module srld_back
  import srld_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] clear_index,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  cmd_t             pop_cmd,
  srld_pixel_if.source     pixels
);

  logic               cur_valid;
  logic [IDX_W-1:0]   cur_idx;
  logic [COL_W-1:0]   cur_col;
  logic [COUNT_W-1:0] cur_rem;
  logic               out_free;
  logic               emit;
  logic               cur_last;

  // Output register frees up when empty or being taken
  assign out_free  = !pixels.valid || pixels.ready;
  assign emit      = cur_valid && out_free;
  assign cur_last  = (cur_rem == COUNT_W'(1));
  assign pop_ready = !cur_valid || (emit && cur_last);

  // Walk the current span one pixel per word
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop_ready) begin
      cur_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready) begin
      cur_idx <= pop_cmd.idx;
      cur_col <= pop_cmd.col;
      cur_rem <= pop_cmd.count;
    end else if (emit) begin
      cur_col <= cur_col + COL_W'(1);
      cur_rem <= cur_rem - COUNT_W'(1);
    end
  end

  // Hold the pixel word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pixels.valid <= 1'b0;
    end else if (out_free) begin
      pixels.valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixels.pixel_index       <= cur_idx;
      pixels.column            <= cur_col;
      pixels.transparent       <= (cur_idx >= clear_index);
      pixels.super_transparent <= (cur_idx == clear_index);
      pixels.last              <= cur_last;
    end
  end

endmodule

### hw/rtl/scanline_rle_pixel_decoder_top.sv
// Top level of the scanline run-length pixel decoder.
// Takes one compressed code word per cycle while the four-entry span queue has room; a literal
// yields one pixel word, a run code plus its index byte yield up to 31 pixel words, and the
// back end emits one pixel word per cycle while its output is taken, so a long run keeps the back
// end busy and input stalls once the span queue fills. Results pass through the span queue, the
// span registers and the output register. Configuration (row_width at index 0, clear_index at
// index 1) is written through cfg_we/cfg_index/cfg_data and takes effect on the next cycle.
module scanline_rle_pixel_decoder_top
  import srld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  srld_code_if.sink             codes,
  srld_pixel_if.source          pixels
);

  logic [COL_W-1:0] row_width;
  logic [IDX_W-1:0] clear_index;
  logic             push_valid;
  logic             push_ready;
  cmd_t             push_cmd;
  logic             pop_valid;
  logic             pop_ready;
  cmd_t             pop_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= ROW_WIDTH_RST;
      clear_index <= CLEAR_INDEX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_WIDTH:   row_width   <= cfg_data[COL_W-1:0];
        REG_CLEAR_INDEX: clear_index <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  srld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .row_width  (row_width),
    .codes      (codes),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  srld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  srld_back u_back (
    .clk         (clk),
    .rst         (rst),
    .clear_index (clear_index),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_cmd     (pop_cmd),
    .pixels      (pixels)
  );

endmodule

### verif/scanline_rle_pixel_decoder_top_tb.sv
// Self-checking testbench for the scanline run-length pixel decoder top level.
module scanline_rle_pixel_decoder_top_tb;
  import srld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_TOTAL = 410;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // One decoded pixel word as the block reports it
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [COL_W-1:0] col;
    logic             transparent;
    logic             super_transparent;
    logic             last;
  } pixel_word_t;

  // Scanline decode predictor and the queue of pixel words it expects
  class pixel_scoreboard;
    logic [COL_W-1:0]   row_width;
    logic [IDX_W-1:0]   clear_index;
    logic [COL_W-1:0]   column;
    bit                 run_armed;
    logic [COUNT_W-1:0] run_len;
    pixel_word_t        expected_q[$];
    int unsigned        failures;

    function void reset_state();
      row_width   = ROW_WIDTH_RST;
      clear_index = CLEAR_INDEX_RST;
      column      = '0;
      run_armed   = 1'b0;
      run_len     = '0;
      expected_q.delete();
      failures    = 0;
    endfunction

    // Pixels left in the row; a 12-bit width never exceeds the maximum row size
    function int unsigned room();
      return (column < row_width) ? int'(row_width) - int'(column) : 0;
    endfunction

    function void emit(logic [IDX_W-1:0] idx, bit is_last);
      pixel_word_t w;
      w.idx               = idx;
      w.col               = column;
      w.transparent       = (idx >= clear_index);
      w.super_transparent = (idx == clear_index);
      w.last              = is_last;
      expected_q.insert(expected_q.size(), w);
      column = column + 1'b1;
    endfunction

    // Note one accepted code word and queue the pixels it yields
    function void note_code(logic [IDX_W-1:0] code, logic row_end);
      int unsigned n;
      if (run_armed) begin
        n = run_len;
        if (n > room()) n = room();
        for (int unsigned j = 0; j < n; j++) emit(code, j + 1 == n);
        run_armed = 1'b0;
        run_len   = '0;
      end else if (room() > 0) begin
        if ((code & RUN_MARK) == RUN_MARK) begin
          n = code & RUN_COUNT_MASK;
          if (n > room()) n = room();
          run_len   = n[COUNT_W-1:0];
          run_armed = 1'b1;
        end else begin
          emit(code, 1'b1);
        end
      end
      // Row end drops the column and any run still waiting for its index
      if (row_end) begin
        column    = '0;
        run_armed = 1'b0;
        run_len   = '0;
      end
    endfunction

    // Compare one accepted pixel word with the oldest expectation
    function void check_pixel(logic [IDX_W-1:0] idx, logic [COL_W-1:0] col, logic tr,
                              logic st, logic last);
      pixel_word_t got;
      pixel_word_t want;
      got = {idx, col, tr, st, last};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected pixel word idx=%0d col=%0d tr=%b st=%b last=%b",
                 $time, idx, col, tr, st, last);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $display("%0t: pixel mismatch expected idx=%0d col=%0d tr=%b st=%b last=%b",
                 $time, want.idx, want.col, want.transparent, want.super_transparent,
                 want.last);
        $display("%0t:                actual   idx=%0d col=%0d tr=%b st=%b last=%b",
                 $time, idx, col, tr, st, last);
        failures++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srld_code_if  codes_if ();
  srld_pixel_if pixels_if ();

  pixel_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     random_sent;

  scanline_rle_pixel_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .codes     (codes_if),
    .pixels    (pixels_if)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check pixel words and stall the output at random
  always @(posedge clk) begin
    if (!rst && pixels_if.valid && pixels_if.ready) begin
      sb.check_pixel(pixels_if.pixel_index, pixels_if.column, pixels_if.transparent,
                     pixels_if.super_transparent, pixels_if.last);
    end
    pixels_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hold off the input at random, then offer one code word until it is taken
  task automatic send_code(input logic [IDX_W-1:0] code, input logic row_end);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      codes_if.valid <= 1'b0;
      @(posedge clk);
    end
    codes_if.valid     <= 1'b1;
    codes_if.data_byte <= code;
    codes_if.row_end   <= row_end;
    do @(posedge clk); while (!codes_if.ready);
    sb.note_code(code, row_end);
  endtask

  // Drain every expected pixel word, then let the back end settle
  task automatic wait_idle();
    codes_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back
  task automatic set_config(input logic [COL_W-1:0] width, input logic [IDX_W-1:0] clear);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROW_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= REG_CLEAR_INDEX;
    cfg_data  <= {{(CFG_DATA_W - IDX_W){1'b0}}, clear};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.row_width   = width;
    sb.clear_index = clear;
  endtask

  // Run index that often lands on or next to the clear index
  function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] clear);
    case ($urandom_range(0, 5))
      0:       return clear;
      1:       return clear - 1'b1;
      2:       return clear + 1'b1;
      default: return IDX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed rows of literals and runs, with some noise bytes
  task automatic run_random_phase(input logic [COL_W-1:0] width, input logic [IDX_W-1:0] clear,
                                  input int unsigned items, input bit wide_row);
    int unsigned sent;
    int unsigned roll;
    logic [IDX_W-1:0] code;
    bit end_row;
    sent = 0;
    wait_idle();
    set_config(width, clear);
    while (sent < items) begin
      case ((random_sent + sent) * 3 / RANDOM_TOTAL)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (wide_row) begin
        end_row = (sb.room() == 0);
      end else begin
        end_row = (sb.room() == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 39) == 0;
      end
      if (roll < 10) begin
        send_code(IDX_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        sent += 1;
      end else if (roll < 45 && !wide_row) begin
        send_code(IDX_W'($urandom_range(0, 8'hdf)), end_row);
        sent += 1;
      end else begin
        code = RUN_MARK | IDX_W'(wide_row ? $urandom_range(24, 31) : $urandom_range(0, 31));
        send_code(code, !wide_row && $urandom_range(0, 29) == 0);
        send_code(pick_index(clear), end_row);
        sent += 2;
      end
    end
    random_sent += sent;
  endtask

  // End the run if it hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new;
    sb.reset_state();
    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_ROW_WIDTH;
    cfg_data            = '0;
    codes_if.valid      = 1'b0;
    codes_if.data_byte  = '0;
    codes_if.row_end    = 1'b0;
    pixels_if.ready     = 1'b0;
    send_idle_pct       = 9;
    recv_idle_pct       = 45;
    random_sent         = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Short row: literal extremes, zero run, clipped run, full row, run code on row end
    set_config(12'd8, 8'h80);
    send_code(8'h00, 1'b0);
    send_code(8'hdf, 1'b0);
    send_code(8'he0, 1'b0);
    send_code(8'h55, 1'b0);
    send_code(8'hff, 1'b0);
    send_code(8'h80, 1'b0);
    send_code(8'h11, 1'b0);
    send_code(8'he2, 1'b0);
    send_code(8'h33, 1'b1);
    send_code(8'he5, 1'b1);
    send_code(8'h12, 1'b0);
    send_code(8'h7f, 1'b1);
    send_code(8'hfe, 1'b0);

    // Lower the width while the run waits for its index
    wait_idle();
    set_config(12'd3, 8'h80);
    send_code(8'h44, 1'b1);

    // Zero width drops every byte
    wait_idle();
    set_config(12'd0, 8'hff);
    send_code(8'h01, 1'b0);
    send_code(8'he3, 1'b0);
    send_code(8'h02, 1'b1);

    run_random_phase(12'd64, 8'd254, 40, 1'b0);
    run_random_phase(12'd1, 8'd0, 30, 1'b0);
    run_random_phase(12'd17, 8'd255, 40, 1'b0);
    run_random_phase(12'd4095, 8'd128, 240, 1'b1);
    run_random_phase(12'd200, IDX_W'($urandom_range(0, 255)), 30, 1'b0);
    run_random_phase(12'd5, 8'd1, 30, 1'b0);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/srld_pkg.sv
hw/rtl/srld_code_if.sv
hw/rtl/srld_pixel_if.sv
hw/rtl/srld_front.sv
hw/rtl/srld_queue.sv
hw/rtl/srld_back.sv
hw/rtl/scanline_rle_pixel_decoder_top.sv
verif/scanline_rle_pixel_decoder_top_tb.sv
